>>> src/pec_pkg.sv
`timescale 1ns / 1ps
// pec_pkg: shared constants for the page eeprom controller
// register select codes, command op codes, status bit positions, config indices, defaults, access_bytes
// no dependencies
package pec_pkg;

  localparam int PAGE_BYTES_DEF = 64;
  localparam int PAGE_COUNT_DEF = 64;

  localparam int SEL_W    = 3;
  localparam int WORD_W   = 32;
  localparam int CFG_IDX_W = 4;

  localparam logic [SEL_W-1:0] SEL_ADDR     = 3'd0;
  localparam logic [SEL_W-1:0] SEL_CMD      = 3'd1;
  localparam logic [SEL_W-1:0] SEL_WDATA    = 3'd2;
  localparam logic [SEL_W-1:0] SEL_RDATA    = 3'd3;
  localparam logic [SEL_W-1:0] SEL_STATUS   = 3'd4;
  localparam logic [SEL_W-1:0] SEL_STAT_CLR = 3'd5;

  localparam logic [2:0] OP_RD8        = 3'd0;
  localparam logic [2:0] OP_RD16       = 3'd1;
  localparam logic [2:0] OP_RD32       = 3'd2;
  localparam logic [2:0] OP_WR8        = 3'd3;
  localparam logic [2:0] OP_WR16       = 3'd4;
  localparam logic [2:0] OP_WR32       = 3'd5;
  localparam logic [2:0] OP_ERASE_PROG = 3'd6;

  localparam int BIT_RDWR_DONE = 26;
  localparam int BIT_PROG_DONE = 28;

  localparam logic [CFG_IDX_W-1:0] CFG_IEN = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PD  = 4'd1;

  function automatic logic [2:0] access_bytes(input logic [2:0] op);
    logic [2:0] n;
    case (op)
      OP_RD8, OP_WR8:   n = 3'd1;
      OP_RD16, OP_WR16: n = 3'd2;
      default:          n = 3'd4;
    endcase
    return n;
  endfunction

endpackage

>>> src/page_eeprom_controller.sv
`timescale 1ns / 1ps
// page_eeprom_controller: register-level eeprom controller with a page latch
// byte-serial store and latch memories under a small sequencer
// depends on pec_pkg
//
//  channel | direction | handshake             | word
//  in      | input     | in_valid / in_ready   | in_operation, in_register_select, in_write_data
//  out     | output    | out_valid / out_ready | out_read_data, out_irq
//  cfg     | input     | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// one word at a time; data accesses go byte by byte through each memory's byte-wide ports
// page and store sizes must be powers of two (not checked here), so an address write is a mask
// erase/program: latch bytes are copied into the addressed store page, one latch byte per cycle
// after reset a clearing pass over every store and latch byte holds in_ready low
// a finished word waits in the output register; the next word is taken meanwhile
module page_eeprom_controller #(
  parameter int PAGE_BYTES = pec_pkg::PAGE_BYTES_DEF,
  parameter int PAGE_COUNT = pec_pkg::PAGE_COUNT_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_operation,
  input  logic [pec_pkg::SEL_W-1:0]     in_register_select,
  input  logic [pec_pkg::WORD_W-1:0]    in_write_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [pec_pkg::WORD_W-1:0]    out_read_data,
  output logic                          out_irq,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [pec_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [pec_pkg::WORD_W-1:0]    cfg_data
);

  localparam int STORE_BYTES = PAGE_BYTES * PAGE_COUNT;
  localparam int AW = $clog2(STORE_BYTES);
  localparam int PW = $clog2(PAGE_BYTES);
  localparam logic [AW:0]   PB_W      = (AW+1)'(PAGE_BYTES);
  localparam logic [AW-1:0] ADDR_LAST = AW'(STORE_BYTES - 1);
  localparam logic [PW-1:0] OFF_LAST  = PW'(PAGE_BYTES - 1);
  localparam logic [PW:0]   PB_CNT    = (PW+1)'(PAGE_BYTES);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_CLEAR = 4'd1;
  localparam logic [3:0] S_RD    = 4'd4;
  localparam logic [3:0] S_WR    = 4'd5;
  localparam logic [3:0] S_PROG  = 4'd6;
  localparam logic [3:0] S_DONE  = 4'd7;

  logic [3:0]  st_r, st_nxt;
  logic [AW-1:0] clr_r, clr_nxt;
  logic [AW-1:0] addr_r, addr_nxt;
  logic [PW-1:0] off_r, off_nxt;
  logic [3:0]  cmd_r, cmd_nxt;
  logic [1:0]  stat_r, stat_nxt;
  logic [1:0]  ien_r, ien_nxt;
  logic        pd_r, pd_nxt;
  logic [31:0] q_r, q_nxt;
  logic [PW:0] byte_cnt_r, byte_cnt_nxt;
  logic [2:0]  nbytes_r, nbytes_nxt;
  logic        rvld_r, rvld_nxt;
  logic [1:0]  rcv_r, rcv_nxt;
  logic [AW-1:0] pa_r, pa_nxt;
  logic        pvld_r, pvld_nxt;
  logic [31:0] rd_r, rd_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [31:0] out_data_r, out_data_nxt;
  logic        out_irq_r, out_irq_nxt;

  logic [7:0]    store_mem [STORE_BYTES];
  logic [7:0]    latch_mem [PAGE_BYTES];
  logic          store_we, latch_we;
  logic [AW-1:0] store_wa;
  logic [PW-1:0] latch_wa, latch_ra;
  logic [7:0]    store_wd, latch_wd, store_q, latch_q;

  logic [AW-1:0] addr_inc;
  logic [PW-1:0] off_inc;
  logic [2:0]    cmd_op;

  assign in_ready      = (st_r == S_IDLE);
  assign cfg_ready     = 1'b1;
  assign out_valid     = out_valid_r;
  assign out_read_data = out_data_r;
  assign out_irq       = out_irq_r;

  assign addr_inc = (addr_r == ADDR_LAST) ? '0 : addr_r + 1'b1;
  assign off_inc  = (off_r == OFF_LAST) ? '0 : off_r + 1'b1;
  assign cmd_op   = cmd_r[2:0];
  assign latch_ra = byte_cnt_r[PW-1:0];

  always_comb begin
    st_nxt       = st_r;
    clr_nxt      = clr_r;
    addr_nxt     = addr_r;
    off_nxt      = off_r;
    cmd_nxt      = cmd_r;
    stat_nxt     = stat_r;
    ien_nxt      = ien_r;
    pd_nxt       = pd_r;
    q_nxt        = q_r;
    byte_cnt_nxt = byte_cnt_r;
    nbytes_nxt   = nbytes_r;
    rvld_nxt     = 1'b0;
    rcv_nxt      = rcv_r;
    pa_nxt       = pa_r;
    pvld_nxt     = 1'b0;
    rd_nxt       = rd_r;
    out_valid_nxt = out_valid_r & ~out_ready;
    out_data_nxt = out_data_r;
    out_irq_nxt  = out_irq_r;
    store_we     = 1'b0;
    store_wa     = pa_r;
    store_wd     = latch_q;
    latch_we     = 1'b0;
    latch_wa     = off_r;
    latch_wd     = q_r[7:0];

    if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        pec_pkg::CFG_IEN: ien_nxt = cfg_data[1:0];
        pec_pkg::CFG_PD:  pd_nxt  = cfg_data[0];
        default: ;
      endcase
    end

    case (st_r)
      S_CLEAR: begin
        store_we = 1'b1;
        store_wa = clr_r;
        store_wd = '0;
        latch_wa = clr_r[PW-1:0];
        latch_wd = '0;
        latch_we = ({1'b0, clr_r} < PB_W);
        clr_nxt  = clr_r + 1'b1;
        if (clr_r == ADDR_LAST) begin
          st_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          rd_nxt = '0;
          st_nxt = S_DONE;
          if (in_operation) begin
            case (in_register_select)
              pec_pkg::SEL_ADDR: begin
                addr_nxt = in_write_data[AW-1:0];
                off_nxt  = in_write_data[PW-1:0];
              end
              pec_pkg::SEL_CMD: begin
                if (!pd_r) begin
                  cmd_nxt = in_write_data[3:0];
                  if (in_write_data[2:0] == pec_pkg::OP_ERASE_PROG) begin
                    pa_nxt       = addr_r - AW'(off_r);
                    byte_cnt_nxt = '0;
                    st_nxt       = S_PROG;
                  end
                end
              end
              pec_pkg::SEL_WDATA: begin
                if (!pd_r && cmd_op >= pec_pkg::OP_WR8 && cmd_op <= pec_pkg::OP_WR32) begin
                  q_nxt        = in_write_data;
                  nbytes_nxt   = pec_pkg::access_bytes(cmd_op);
                  byte_cnt_nxt = '0;
                  st_nxt       = S_WR;
                end
              end
              pec_pkg::SEL_STAT_CLR: begin
                if (in_write_data[pec_pkg::BIT_RDWR_DONE]) stat_nxt[0] = 1'b0;
                if (in_write_data[pec_pkg::BIT_PROG_DONE]) stat_nxt[1] = 1'b0;
              end
              default: ;
            endcase
          end else begin
            case (in_register_select)
              pec_pkg::SEL_ADDR: rd_nxt = 32'(addr_r);
              pec_pkg::SEL_CMD:  rd_nxt = 32'(cmd_r);
              pec_pkg::SEL_RDATA: begin
                if (!pd_r && cmd_op <= pec_pkg::OP_RD32) begin
                  nbytes_nxt   = pec_pkg::access_bytes(cmd_op);
                  byte_cnt_nxt = '0;
                  rcv_nxt      = '0;
                  st_nxt       = S_RD;
                end
              end
              pec_pkg::SEL_STATUS: begin
                rd_nxt[pec_pkg::BIT_RDWR_DONE] = stat_r[0];
                rd_nxt[pec_pkg::BIT_PROG_DONE] = stat_r[1];
              end
              default: ;
            endcase
          end
        end
      end
      S_WR: begin
        latch_we     = 1'b1;
        q_nxt        = {8'd0, q_r[31:8]};
        addr_nxt     = addr_inc;
        off_nxt      = off_inc;
        byte_cnt_nxt = byte_cnt_r + 1'b1;
        if (byte_cnt_r + 1'b1 == (PW+1)'(nbytes_r)) begin
          stat_nxt[0] = 1'b1;
          st_nxt      = S_DONE;
        end
      end
      S_RD: begin
        if (byte_cnt_r < (PW+1)'(nbytes_r)) begin
          byte_cnt_nxt = byte_cnt_r + 1'b1;
          addr_nxt     = addr_inc;
          off_nxt      = off_inc;
          rvld_nxt     = 1'b1;
        end
        if (rvld_r) begin
          rd_nxt[{rcv_r, 3'b000} +: 8] = store_q;
          rcv_nxt = rcv_r + 1'b1;
          if (rcv_r == 2'(nbytes_r - 3'd1)) begin
            stat_nxt[0] = 1'b1;
            st_nxt      = S_DONE;
          end
        end
      end
      S_PROG: begin
        if (byte_cnt_r < PB_CNT) begin
          byte_cnt_nxt = byte_cnt_r + 1'b1;
          pvld_nxt     = 1'b1;
        end
        if (pvld_r) begin
          store_we = 1'b1;
          pa_nxt   = pa_r + 1'b1;
        end
        if (byte_cnt_r == PB_CNT && !pvld_r) begin
          stat_nxt[1] = 1'b1;
          st_nxt      = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = rd_r;
          out_irq_nxt   = |(stat_r & ien_r);
          st_nxt        = S_IDLE;
        end
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= S_CLEAR;
      clr_r       <= '0;
      addr_r      <= '0;
      off_r       <= '0;
      cmd_r       <= '0;
      stat_r      <= '0;
      ien_r       <= '0;
      pd_r        <= 1'b1;
      rvld_r      <= 1'b0;
      pvld_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      clr_r       <= clr_nxt;
      addr_r      <= addr_nxt;
      off_r       <= off_nxt;
      cmd_r       <= cmd_nxt;
      stat_r      <= stat_nxt;
      ien_r       <= ien_nxt;
      pd_r        <= pd_nxt;
      rvld_r      <= rvld_nxt;
      pvld_r      <= pvld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    q_r        <= q_nxt;
    byte_cnt_r <= byte_cnt_nxt;
    nbytes_r   <= nbytes_nxt;
    rcv_r      <= rcv_nxt;
    pa_r       <= pa_nxt;
    rd_r       <= rd_nxt;
    out_data_r <= out_data_nxt;
    out_irq_r  <= out_irq_nxt;
  end

  // store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (store_we) begin
      store_mem[store_wa] <= store_wd;
    end
    store_q <= store_mem[addr_r];
  end

  // page latch
  always_ff @(posedge clk) begin
    if (latch_we) begin
      latch_mem[latch_wa] <= latch_wd;
    end
    latch_q <= latch_mem[latch_ra];
  end

`ifndef SYNTHESIS
  a_addr_range: assert property (@(posedge clk) disable iff (!rst_n)
    (addr_r <= ADDR_LAST))
    else $error("address beyond store");
  a_off_range: assert property (@(posedge clk) disable iff (!rst_n)
    ({1'b0, off_r} < PB_CNT))
    else $error("page offset beyond page");
  a_no_store_wr_in_rd: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_RD || st_r == S_IDLE) |-> !store_we)
    else $error("store written outside clear or program");
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("word taken while previous still in work");
`endif

endmodule

>>> sim/pec_reply_checker.sv
`timescale 1ns / 1ps
// pec_reply_checker: watches the bus, config and reply channels of the page eeprom
// controller, tracks store, page latch and registers, and compares every reply word
// depends on pec_pkg
module pec_reply_checker (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic                          in_ready,
  input  logic                          in_operation,
  input  logic [pec_pkg::SEL_W-1:0]     in_register_select,
  input  logic [pec_pkg::WORD_W-1:0]    in_write_data,
  input  logic                          out_valid,
  input  logic                          out_ready,
  input  logic [pec_pkg::WORD_W-1:0]    out_read_data,
  input  logic                          out_irq,
  input  logic                          cfg_valid,
  input  logic                          cfg_ready,
  input  logic [pec_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [pec_pkg::WORD_W-1:0]    cfg_data,
  output int                            words_in_flight,
  output int                            mismatch_count
);

  localparam int unsigned PAGE_SIZE  = pec_pkg::PAGE_BYTES_DEF;
  localparam int unsigned STORE_SIZE = pec_pkg::PAGE_BYTES_DEF * pec_pkg::PAGE_COUNT_DEF;

  typedef struct packed {
    logic [pec_pkg::WORD_W-1:0] data;
    logic                       irq;
  } bus_reply_t;

  logic [7:0]  store_mem [STORE_SIZE];
  logic [7:0]  latch_mem [PAGE_SIZE];
  int unsigned addr_q;
  logic [3:0]  cmd_q;
  logic [1:0]  status_q;
  logic [1:0]  ien_q;
  logic        pd_q;

  bus_reply_t replies_due [$];

  initial begin
    words_in_flight = 0;
    mismatch_count  = 0;
  end

  function automatic bus_reply_t model_access(input logic wr,
                                              input logic [pec_pkg::SEL_W-1:0] sel,
                                              input logic [pec_pkg::WORD_W-1:0] d);
    bus_reply_t  r;
    logic [2:0]  op;
    int unsigned n;
    int unsigned off;
    int unsigned base;
    r.data = '0;
    op = cmd_q[2:0];
    n = (op % 3 == 0) ? 1 : ((op % 3 == 1) ? 2 : 4);
    if (wr) begin
      case (sel)
        pec_pkg::SEL_ADDR: addr_q = d % STORE_SIZE;
        pec_pkg::SEL_CMD: if (!pd_q) begin
          cmd_q = d[3:0];
          if (cmd_q[2:0] == pec_pkg::OP_ERASE_PROG) begin
            base = addr_q - (addr_q % PAGE_SIZE);
            for (int unsigned i = 0; i < PAGE_SIZE; i++) store_mem[base + i] = latch_mem[i];
            status_q[1] = 1'b1;
          end
        end
        pec_pkg::SEL_WDATA: if (!pd_q && op >= pec_pkg::OP_WR8 && op <= pec_pkg::OP_WR32) begin
          off = addr_q % PAGE_SIZE;
          for (int unsigned i = 0; i < n; i++) latch_mem[(off + i) % PAGE_SIZE] = d[8*i +: 8];
          addr_q = (addr_q + n) % STORE_SIZE;
          status_q[0] = 1'b1;
        end
        pec_pkg::SEL_STAT_CLR: begin
          if (d[pec_pkg::BIT_RDWR_DONE]) status_q[0] = 1'b0;
          if (d[pec_pkg::BIT_PROG_DONE]) status_q[1] = 1'b0;
        end
        default: ;
      endcase
    end else begin
      case (sel)
        pec_pkg::SEL_ADDR: r.data = addr_q;
        pec_pkg::SEL_CMD:  r.data = {28'd0, cmd_q};
        pec_pkg::SEL_RDATA: if (!pd_q && op <= pec_pkg::OP_RD32) begin
          for (int unsigned i = 0; i < n; i++)
            r.data[8*i +: 8] = store_mem[(addr_q + i) % STORE_SIZE];
          addr_q = (addr_q + n) % STORE_SIZE;
          status_q[0] = 1'b1;
        end
        pec_pkg::SEL_STATUS: begin
          r.data[pec_pkg::BIT_RDWR_DONE] = status_q[0];
          r.data[pec_pkg::BIT_PROG_DONE] = status_q[1];
        end
        default: ;
      endcase
    end
    r.irq = |(status_q & ien_q);
    return r;
  endfunction

  task automatic flag_failure(input string msg);
    mismatch_count++;
    if (mismatch_count <= 10) $display("%0t: %s", $realtime, msg);
  endtask

  always @(posedge clk) begin
    bus_reply_t want;
    if (!rst_n) begin
      foreach (store_mem[i]) store_mem[i] = 8'h00;
      foreach (latch_mem[i]) latch_mem[i] = 8'h00;
      addr_q   = 0;
      cmd_q    = '0;
      status_q = '0;
      ien_q    = '0;
      pd_q     = 1'b1;
      replies_due.delete();
      words_in_flight = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == pec_pkg::CFG_IEN) ien_q = cfg_data[1:0];
        else if (cfg_index == pec_pkg::CFG_PD) pd_q = cfg_data[0];
      end
      if (out_valid && out_ready) begin
        if (replies_due.size() == 0) begin
          flag_failure($sformatf("unexpected word read_data %h irq %b",
                                 out_read_data, out_irq));
        end else begin
          want = replies_due.pop_front();
          if (out_read_data !== want.data)
            flag_failure($sformatf("read_data expected %h got %h", want.data, out_read_data));
          if (out_irq !== want.irq)
            flag_failure($sformatf("irq expected %b got %b", want.irq, out_irq));
        end
      end
      if (in_valid && in_ready)
        replies_due.push_back(model_access(in_operation, in_register_select, in_write_data));
      words_in_flight = replies_due.size();
    end
  end

endmodule

>>> sim/tb_top.sv
`timescale 1ns / 1ps
// tb_top: stimulus and verdict for page_eeprom_controller
// drives bus accesses, config writes and reply backpressure; checking is in pec_reply_checker
// depends on pec_pkg, page_eeprom_controller, pec_reply_checker
module tb_top;

  localparam logic                          BUS_RD      = 1'b0;
  localparam logic                          BUS_WR      = 1'b1;
  localparam logic [2:0]                    OP_RESERVED = 3'd7;
  localparam logic [pec_pkg::SEL_W-1:0]     SEL_SPARE_A = 3'd6;
  localparam logic [pec_pkg::SEL_W-1:0]     SEL_SPARE_B = 3'd7;
  localparam logic [pec_pkg::CFG_IDX_W-1:0] CFG_SPARE   = 4'hF;
  localparam logic [pec_pkg::WORD_W-1:0]    CMD_PREFETCH = 32'h8;
  localparam logic [pec_pkg::WORD_W-1:0]    CLR_RDWR    = 32'h1 << pec_pkg::BIT_RDWR_DONE;
  localparam logic [pec_pkg::WORD_W-1:0]    CLR_PROG    = 32'h1 << pec_pkg::BIT_PROG_DONE;
  localparam int unsigned PAGE_SIZE   = pec_pkg::PAGE_BYTES_DEF;
  localparam int unsigned STORE_SIZE  = pec_pkg::PAGE_BYTES_DEF * pec_pkg::PAGE_COUNT_DEF;
  localparam int          SETTLE_CYCLES = 2 * pec_pkg::PAGE_BYTES_DEF + 80;

  logic                          clk;
  logic                          rst_n;
  logic                          in_valid;
  logic                          in_ready;
  logic                          in_operation;
  logic [pec_pkg::SEL_W-1:0]     in_register_select;
  logic [pec_pkg::WORD_W-1:0]    in_write_data;
  logic                          out_valid;
  logic                          out_ready;
  logic [pec_pkg::WORD_W-1:0]    out_read_data;
  logic                          out_irq;
  logic                          cfg_valid;
  logic                          cfg_ready;
  logic [pec_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [pec_pkg::WORD_W-1:0]    cfg_data;

  int words_in_flight;
  int mismatch_count;
  int items_sent;
  bit source_eager;
  bit sink_eager;

  page_eeprom_controller uut (.*);

  pec_reply_checker checker_i (.*);

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  initial begin
    #2_000_000;
    $display("tb_top NOT OK");
    $finish;
  end

  // reply side backpressure
  initial begin
    int stall;
    out_ready = 1'b0;
    @(negedge clk);
    forever begin
      stall = sink_eager ? 0 : $urandom_range(0, 7);
      if (stall > 0) begin
        out_ready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready = 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      @(negedge clk);
    end
  end

  task automatic send(input logic op, input logic [pec_pkg::SEL_W-1:0] sel,
                      input logic [pec_pkg::WORD_W-1:0] d);
    int gap;
    gap = source_eager ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid           = 1'b1;
    in_operation       = op;
    in_register_select = sel;
    in_write_data      = d;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
    in_valid = 1'b0;
    items_sent++;
  endtask

  task automatic cfg_write(input logic [pec_pkg::CFG_IDX_W-1:0] idx,
                           input logic [pec_pkg::WORD_W-1:0] d);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = d;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic wait_all_replies(input bit settle);
    while (words_in_flight != 0) @(negedge clk);
    if (settle) repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic configure(input logic [1:0] ien, input logic pd);
    wait_all_replies(1'b1);
    cfg_write(pec_pkg::CFG_IEN, ($urandom() & ~32'h3) | ien);
    cfg_write(pec_pkg::CFG_PD, ($urandom() & ~32'h1) | pd);
  endtask

  function automatic logic [pec_pkg::WORD_W-1:0] cmd_word(input logic [2:0] op);
    return ($urandom() & ~32'hF) | ($urandom_range(0, 1) ? CMD_PREFETCH : 32'h0) | op;
  endfunction

  // mostly low pages so programmed data gets read back
  function automatic logic [pec_pkg::WORD_W-1:0] addr_word(input bit aligned);
    int unsigned page;
    int unsigned off;
    logic [pec_pkg::WORD_W-1:0] w;
    page = ($urandom_range(0, 4) != 0) ? $urandom_range(0, 7)
                                       : $urandom_range(0, pec_pkg::PAGE_COUNT_DEF - 1);
    off  = aligned ? 0 : $urandom_range(0, PAGE_SIZE - 1);
    w = page * PAGE_SIZE + off;
    if ($urandom_range(0, 3) == 0) w = w + STORE_SIZE * $urandom_range(1, 1000000);
    return w;
  endfunction

  task automatic random_phase(input int quota);
    int stop_at;
    int kind;
    stop_at = items_sent + quota;
    while (items_sent < stop_at) begin
      kind = $urandom_range(0, 9);
      if ($urandom_range(0, 5) == 0) source_eager = !source_eager;
      if ($urandom_range(0, 5) == 0) sink_eager = !sink_eager;
      if ($urandom_range(0, 19) == 0) wait_all_replies(1'b0);
      case (kind)
        0, 1, 2: begin
          send(BUS_WR, pec_pkg::SEL_ADDR, addr_word($urandom_range(0, 1)));
          send(BUS_WR, pec_pkg::SEL_CMD, cmd_word(pec_pkg::OP_WR8 + 3'($urandom_range(0, 2))));
          repeat ($urandom_range(1, 10)) send(BUS_WR, pec_pkg::SEL_WDATA, $urandom());
          if ($urandom_range(0, 3) == 0) send(BUS_WR, pec_pkg::SEL_ADDR, addr_word(1'b0));
          send(BUS_WR, pec_pkg::SEL_CMD, cmd_word(pec_pkg::OP_ERASE_PROG));
          send(BUS_RD, pec_pkg::SEL_STATUS, $urandom());
        end
        3, 4, 5: begin
          send(BUS_WR, pec_pkg::SEL_ADDR, addr_word($urandom_range(0, 1)));
          send(BUS_WR, pec_pkg::SEL_CMD, cmd_word(pec_pkg::OP_RD8 + 3'($urandom_range(0, 2))));
          repeat ($urandom_range(1, 10)) send(BUS_RD, pec_pkg::SEL_RDATA, $urandom());
          if ($urandom_range(0, 1) == 0) send(BUS_RD, pec_pkg::SEL_ADDR, $urandom());
        end
        6, 7: begin
          send(BUS_RD, pec_pkg::SEL_STATUS, $urandom());
          send(BUS_WR, pec_pkg::SEL_STAT_CLR, $urandom() &
               ~(($urandom_range(0, 1) ? CLR_RDWR : 32'h0) |
                 ($urandom_range(0, 1) ? CLR_PROG : 32'h0)));
          send(BUS_RD, pec_pkg::SEL_STATUS, $urandom());
          if ($urandom_range(0, 1) == 0) send(BUS_RD, pec_pkg::SEL_CMD, $urandom());
        end
        default: begin
          repeat ($urandom_range(1, 4))
            send(1'($urandom_range(0, 1)), 3'($urandom_range(0, 7)), $urandom());
        end
      endcase
    end
  endtask

  initial begin
    rst_n              = 1'b0;
    in_valid           = 1'b0;
    in_operation       = BUS_RD;
    in_register_select = pec_pkg::SEL_ADDR;
    in_write_data      = '0;
    cfg_valid          = 1'b0;
    cfg_index          = pec_pkg::CFG_IEN;
    cfg_data           = '0;
    items_sent         = 0;
    source_eager       = 1'b0;
    sink_eager         = 1'b0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // powered down out of reset
    send(BUS_WR, pec_pkg::SEL_CMD, {29'd0, pec_pkg::OP_RD8});
    send(BUS_RD, pec_pkg::SEL_RDATA, 32'h0);
    send(BUS_WR, pec_pkg::SEL_WDATA, 32'hFFFF_FFFF);
    send(BUS_WR, pec_pkg::SEL_ADDR, 32'hFFFF_FFFF);
    send(BUS_RD, pec_pkg::SEL_ADDR, 32'h0);

    configure(2'd3, 1'b0);
    cfg_write(CFG_SPARE, 32'hFFFF_FFFF);
    send(BUS_WR, pec_pkg::SEL_CMD, 32'hFFFF_FFF0 | CMD_PREFETCH | pec_pkg::OP_WR32);
    send(BUS_RD, pec_pkg::SEL_CMD, 32'h0);
    send(BUS_WR, pec_pkg::SEL_WDATA, 32'hA5C3_7E01);
    send(BUS_RD, pec_pkg::SEL_ADDR, 32'h0);
    send(BUS_WR, pec_pkg::SEL_ADDR, PAGE_SIZE);
    send(BUS_WR, pec_pkg::SEL_CMD, {29'd0, pec_pkg::OP_ERASE_PROG});
    send(BUS_RD, pec_pkg::SEL_STATUS, 32'h0);
    send(BUS_WR, pec_pkg::SEL_STAT_CLR, CLR_RDWR);
    send(BUS_RD, pec_pkg::SEL_STATUS, 32'h0);
    send(BUS_WR, pec_pkg::SEL_ADDR, STORE_SIZE - PAGE_SIZE);
    send(BUS_WR, pec_pkg::SEL_CMD, {29'd0, pec_pkg::OP_ERASE_PROG});
    send(BUS_WR, pec_pkg::SEL_CMD, {29'd0, pec_pkg::OP_RD32});
    send(BUS_WR, pec_pkg::SEL_ADDR, 32'hFFFF_FFFE);
    send(BUS_RD, pec_pkg::SEL_RDATA, 32'h0);
    send(BUS_WR, pec_pkg::SEL_CMD, {29'd0, OP_RESERVED});
    send(BUS_RD, pec_pkg::SEL_RDATA, 32'h0);
    send(BUS_WR, pec_pkg::SEL_WDATA, 32'h0);
    send(BUS_RD, pec_pkg::SEL_WDATA, 32'h0);
    send(BUS_RD, pec_pkg::SEL_STAT_CLR, 32'h0);
    send(BUS_WR, pec_pkg::SEL_RDATA, 32'hFFFF_FFFF);
    send(BUS_WR, pec_pkg::SEL_STATUS, 32'hFFFF_FFFF);
    send(BUS_RD, SEL_SPARE_A, 32'hFFFF_FFFF);
    send(BUS_WR, SEL_SPARE_B, 32'hFFFF_FFFF);
    send(BUS_WR, pec_pkg::SEL_STAT_CLR, 32'hFFFF_FFFF);

    configure(2'd3, 1'b0);
    random_phase(245);
    configure(2'd0, 1'b0);
    random_phase(245);
    configure(2'd1, 1'b0);
    random_phase(245);
    configure(2'd2, 1'b1);
    random_phase(60);
    configure(2'($urandom_range(0, 3)), 1'b0);
    random_phase(245);
    configure(2'd3, 1'b0);
    random_phase(245);

    wait_all_replies(1'b1);
    if (mismatch_count == 0 && words_in_flight == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule

>>> filelist.f
src/pec_pkg.sv
src/page_eeprom_controller.sv
sim/pec_reply_checker.sv
sim/tb_top.sv
